FILE: design/acm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types, constants and AES-128 helper functions for the CMAC tag engine.
// ----------------------------------------------------------------------------
package acm_pkg;

    // Default number of tag bytes packed into the result.
    localparam int TAG_BYTES_DEFAULT = 4;

    // Depth of the job queue between the byte assembler and the AES engine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Number of AES-128 rounds.
    localparam logic [3:0] AES_ROUNDS = 4'd10;

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY_UPPER = 2'd0;
    localparam logic [1:0] REG_KEY_LOWER = 2'd1;

    // Reduction constant for doubling in GF(2^128).
    localparam logic [127:0] CMAC_RB = 128'h87;
    // First byte of the padding on a partial final block.
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Back end state.
    typedef enum logic [0:0] {
        BK_IDLE,
        BK_RUN
    } bk_state_t;

    // One block job handed from the front to the back.
    typedef struct packed {
        logic [127:0] blk;
        logic         final_blk;
        logic         use_k1;
    } acm_job_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Round constant for the key schedule step that leads into round r.
    function automatic logic [7:0] aes_rcon(input logic [3:0] r);
        logic [7:0] v;
        unique case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block, byte 0 in the top bits.
    function automatic logic [7:0] blk_byte(input logic [127:0] b, input int i);
        return b[127 - 8 * i -: 8];
    endfunction

    // One step of the AES-128 key schedule.
    function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
        w0 = rk[127:96];
        w1 = rk[95:64];
        w2 = rk[63:32];
        w3 = rk[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        n0 = w0 ^ t;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // One AES round without the round key addition.
    function automatic logic [127:0] aes_round(input logic [127:0] st, input logic last_rnd);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, x;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) begin
            s[i] = SBOX[blk_byte(st, i)];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4 * c] = s[i + 4 * ((c + i) & 3)];
            end
        end
        if (!last_rnd) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4 * c];
                a1 = t[4 * c + 1];
                a2 = t[4 * c + 2];
                a3 = t[4 * c + 3];
                x  = a0 ^ a1 ^ a2 ^ a3;
                t[4 * c]     = a0 ^ x ^ xtime(a0 ^ a1);
                t[4 * c + 1] = a1 ^ x ^ xtime(a1 ^ a2);
                t[4 * c + 2] = a2 ^ x ^ xtime(a2 ^ a3);
                t[4 * c + 3] = a3 ^ x ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[127 - 8 * i -: 8] = t[i];
        end
        return res;
    endfunction

    // Doubling in GF(2^128) as used for the CMAC subkeys.
    function automatic logic [127:0] gf_double(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ (v[127] ? CMAC_RB : 128'd0);
    endfunction

endpackage
`default_nettype wire

FILE: design/acm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acm_front
// Byte assembler: packs message bytes into 16-byte blocks and issues block
// jobs (chained or final) to the job queue.
// ----------------------------------------------------------------------------
module acm_front
    import acm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_fire,
    input  wire logic [7:0] data_byte,
    input  wire logic     byte_present,
    input  wire logic     end_of_message,
    output acm_job_t      job_a,
    output logic          push_a,
    output acm_job_t      job_b,
    output logic          push_b
);

    logic [127:0] buf_reg, buf_next;
    logic [4:0]   fill_reg, fill_next;
    logic [127:0] cur_buf;
    logic [4:0]   cur_fill;
    logic [127:0] pad_blk;

    // Byte placement and job forming for the accepted item.
    always_comb
    begin
        cur_buf  = buf_reg;
        cur_fill = fill_reg;
        push_a   = 1'b0;
        job_a    = '{blk: buf_reg, final_blk: 1'b0, use_k1: 1'b0};
        if (in_fire && byte_present) begin
            // A full block is chained only once another byte shows it is not last.
            if (fill_reg[4]) begin
                push_a   = 1'b1;
                cur_buf  = '0;
                cur_fill = '0;
            end
            for (int i = 0; i < 16; i++) begin
                if (cur_fill[3:0] == 4'(i)) begin
                    cur_buf[127 - 8 * i -: 8] = data_byte;
                end
            end
            cur_fill = cur_fill + 5'd1;
        end

        // Padded copy for a partial final block.
        pad_blk = cur_buf;
        for (int i = 0; i < 16; i++) begin
            if (cur_fill[3:0] == 4'(i)) begin
                pad_blk[127 - 8 * i -: 8] = PAD_BYTE;
            end
        end

        push_b = in_fire && end_of_message;
        job_b  = '{blk: cur_fill[4] ? cur_buf : pad_blk, final_blk: 1'b1,
                   use_k1: cur_fill[4]};

        buf_next  = cur_buf;
        fill_next = cur_fill;
        if (push_b) begin
            buf_next  = '0;
            fill_next = '0;
        end
    end

    // Block buffer and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            buf_reg  <= '0;
            fill_reg <= '0;
        end else begin
            buf_reg  <= buf_next;
            fill_reg <= fill_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/acm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acm_queue
// Short job queue that takes up to two jobs a cycle and gives one.
// ----------------------------------------------------------------------------
module acm_queue
    import acm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  acm_job_t  job_a,
    input  wire logic push_a,
    input  acm_job_t  job_b,
    input  wire logic push_b,
    output logic      room_two,
    output acm_job_t  head,
    output logic      head_valid,
    input  wire logic pop
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    acm_job_t            mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [1:0]          n_push;

    assign head       = mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign room_two   = (count_reg <= CW'(QUEUE_DEPTH - 2));
    assign n_push     = {1'b0, push_a} + {1'b0, push_b};

    // Pointer and count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(n_push);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + CW'(n_push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; the chained job always goes in ahead of the final one.
    always_ff @(posedge clk)
    begin
        if (push_a) begin
            mem[wr_ptr_reg] <= job_a;
            if (push_b) begin
                mem[wr_ptr_reg + QUEUE_AW'(1)] <= job_b;
            end
        end else if (push_b) begin
            mem[wr_ptr_reg] <= job_b;
        end
    end

endmodule
`default_nettype wire

FILE: design/acm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acm_back
// Round-per-cycle AES-128 engine with the CMAC chain, subkey derivation
// and the tag output register.
// ----------------------------------------------------------------------------
module acm_back
    import acm_pkg::*;
#(
    parameter int TAG_BYTES = TAG_BYTES_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  acm_job_t         head,
    input  wire logic        head_valid,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      mac_tag
);

    bk_state_t    state_reg, state_next;
    logic [127:0] key_reg, key_next;
    logic         stale_reg, stale_next;
    logic [127:0] st_reg, st_next;
    logic [127:0] rk_reg, rk_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic         job_sub_reg, job_sub_next;
    logic         job_fin_reg, job_fin_next;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] k1_reg, k1_next;
    logic [127:0] k2_reg, k2_next;
    logic         out_valid_reg, out_valid_next;
    logic [31:0]  tag_reg, tag_next;
    logic [127:0] subkey;
    logic [127:0] rk_step;
    logic [127:0] rnd_out;
    logic [63:0]  tag_wide;

    assign out_valid = out_valid_reg;
    assign mac_tag   = tag_reg;

    // Datapath of one round.
    always_comb
    begin
        rk_step  = key_step(rk_reg, aes_rcon(rnd_reg));
        rnd_out  = aes_round(st_reg, rnd_reg == AES_ROUNDS) ^ rk_step;
        subkey   = head.final_blk ? (head.use_k1 ? k1_reg : k2_reg) : 128'd0;
        tag_wide = rnd_out[127:64] >> (8 * (8 - TAG_BYTES));
    end

    // Control: start a job, run rounds, retire the result.
    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        stale_next     = stale_reg;
        st_next        = st_reg;
        rk_next        = rk_reg;
        rnd_next       = rnd_reg;
        job_sub_next   = job_sub_reg;
        job_fin_next   = job_fin_reg;
        chain_next     = chain_reg;
        k1_next        = k1_reg;
        k2_next        = k2_reg;
        out_valid_next = out_valid_reg && !out_ready;
        tag_next       = tag_reg;
        pop            = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                rk_next = key_reg;
                if (stale_reg) begin
                    // Subkeys come from the encryption of the zero block.
                    stale_next   = 1'b0;
                    st_next      = key_reg;
                    rnd_next     = 4'd1;
                    job_sub_next = 1'b1;
                    job_fin_next = 1'b0;
                    state_next   = BK_RUN;
                end else if (head_valid && !(head.final_blk && out_valid_reg)) begin
                    pop          = 1'b1;
                    st_next      = chain_reg ^ head.blk ^ subkey ^ key_reg;
                    rnd_next     = 4'd1;
                    job_sub_next = 1'b0;
                    job_fin_next = head.final_blk;
                    state_next   = BK_RUN;
                end
            end
            BK_RUN:
            begin
                rk_next  = rk_step;
                st_next  = rnd_out;
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == AES_ROUNDS) begin
                    state_next = BK_IDLE;
                    if (job_sub_reg) begin
                        k1_next = gf_double(rnd_out);
                        k2_next = gf_double(gf_double(rnd_out));
                    end else if (job_fin_reg) begin
                        chain_next     = '0;
                        out_valid_next = 1'b1;
                        tag_next       = tag_wide[31:0];
                    end else begin
                        chain_next = rnd_out;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        // Key register writes mark the subkeys for rederivation.
        if (cfg_write) begin
            if (cfg_index == REG_KEY_UPPER) begin
                key_next[127:64] = cfg_data;
                stale_next       = 1'b1;
            end else if (cfg_index == REG_KEY_LOWER) begin
                key_next[63:0] = cfg_data;
                stale_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            key_reg       <= '0;
            stale_reg     <= 1'b1;
            chain_reg     <= '0;
            out_valid_reg <= 1'b0;
            rnd_reg       <= '0;
            job_sub_reg   <= 1'b0;
            job_fin_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            key_reg       <= key_next;
            stale_reg     <= stale_next;
            chain_reg     <= chain_next;
            out_valid_reg <= out_valid_next;
            rnd_reg       <= rnd_next;
            job_sub_reg   <= job_sub_next;
            job_fin_reg   <= job_fin_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        rk_reg  <= rk_next;
        k1_reg  <= k1_next;
        k2_reg  <= k2_next;
        tag_reg <= tag_next;
    end

endmodule
`default_nettype wire

FILE: design/aes_cmac_tag_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_cmac_tag_engine_unit
// AES-128 CMAC over a byte stream, giving a truncated tag per message.
// ----------------------------------------------------------------------------
// Usage: load the key through cfg_write/cfg_index/cfg_data (index 0 holds key
// bytes 0..7, index 1 bytes 8..15) while no message is in flight. Each input
// item carries one message byte; end_of_message closes the message, and an
// item with byte_present low and end_of_message high ends an empty message.
// One item per cycle is taken as a rule. A 16-byte block is encrypted by
// the round-per-cycle AES engine before the next block fills. A short job
// queue sits between the byte assembler and the engine; in_ready drops only
// when it lacks room for two jobs. The tag appears when the engine has run
// the final block, which waits while chained blocks are still queued ahead.
// After reset, and after each key write, the engine derives the subkeys
// before it takes the first block. A held output stalls only the final
// block of the next message; bytes keep flowing until the queue fills.
// ----------------------------------------------------------------------------
module aes_cmac_tag_engine_unit
    import acm_pkg::*;
#(
    parameter int TAG_BYTES = TAG_BYTES_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      mac_tag
);

    acm_job_t job_a, job_b, head;
    logic     push_a, push_b, room_two, head_valid, pop, in_fire;

    assign in_ready = room_two;
    assign in_fire  = in_valid && room_two;

    // Byte assembler.
    acm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (in_fire),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .job_a          (job_a),
        .push_a         (push_a),
        .job_b          (job_b),
        .push_b         (push_b)
    );

    // Job queue.
    acm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_a      (job_a),
        .push_a     (push_a),
        .job_b      (job_b),
        .push_b     (push_b),
        .room_two   (room_two),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    // AES engine and tag output.
    acm_back #(
        .TAG_BYTES (TAG_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mac_tag    (mac_tag)
    );

endmodule
`default_nettype wire
